// File: src/bbr_pkg.sv
// bbr_pkg: shared types, constants and the divide-by-nine helper for box_blur_3x3_rgb
// no dependencies; imported by bbr_line_store and box_blur_3x3_rgb
`default_nettype none

package bbr_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CH_W      = 8;
    localparam int SUM_W     = 12;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(800);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(600);

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = CFG_IDX_W'(1);

    // floor(s/9) == (s*3641)>>15 for every s up to 9*255
    localparam int DIV9_MUL_W = 12;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'(3641);
    localparam int DIV9_SHIFT = 15;
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(9 * 255);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+DIV9_MUL_W-1:0] p;
        p = (SUM_W+DIV9_MUL_W)'(s) * (SUM_W+DIV9_MUL_W)'(DIV9_MUL);
        return p[DIV9_SHIFT +: CH_W];
    endfunction

endpackage

`default_nettype wire

// File: src/bbr_line_store.sv
// bbr_line_store: the two line memories (row r-2 and row r-1), one write and one read port each
// depends on bbr_pkg for the pixel type; read data is registered
`default_nettype none

module bbr_line_store #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  wire              i_clk,
    input  wire              i_rd_en,
    input  wire  [AW-1:0]    i_rd_addr,
    input  wire              i_wr_en,
    input  wire  [AW-1:0]    i_wr_addr,
    input  bbr_pkg::t_pix    i_wr_upper,
    input  bbr_pkg::t_pix    i_wr_lower,
    output bbr_pkg::t_pix    o_rd_upper,
    output bbr_pkg::t_pix    o_rd_lower
);
    import bbr_pkg::*;

    t_pix r_mem_upper [MAX_WIDTH];
    t_pix r_mem_lower [MAX_WIDTH];
    t_pix r_rd_upper;
    t_pix r_rd_lower;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_upper[i_wr_addr] <= i_wr_upper;
            r_mem_lower[i_wr_addr] <= i_wr_lower;
        end
        if (i_rd_en) begin
            r_rd_upper <= r_mem_upper[i_rd_addr];
            r_rd_lower <= r_mem_lower[i_rd_addr];
        end
    end

    assign o_rd_upper = r_rd_upper;
    assign o_rd_lower = r_rd_lower;

endmodule

`default_nettype wire

// File: src/box_blur_3x3_rgb.sv
// box_blur_3x3_rgb: streaming 3x3 box blur of an rgb raster, padded by one column and one row
// depends on bbr_pkg and bbr_line_store
//
//   channel   direction   signals
//   in        request     i_in_valid / o_in_ready, i_in_red, i_in_green, i_in_blue
//   out       request     o_out_valid / i_out_ready, o_out_red, o_out_green, o_out_blue,
//                         o_last_of_frame
//   cfg       write       i_cfg_wr_en, i_cfg_index, i_cfg_wdata
//
// one request per clock while the output is not stalled; a result passes these stages:
// line store read, window sum, divide by nine into the output register.
// the line stores are read as a request is accepted and written back in the sum stage.
// reset (synchronous) clears position counters, window and valid bits; line stores
// are not cleared. a stalled output holds back the stages behind it one by one.
`default_nettype none

module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = bbr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbr_pkg::MAX_HEIGHT_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [bbr_pkg::CH_W-1:0]     i_in_red,
    input  wire  [bbr_pkg::CH_W-1:0]     i_in_green,
    input  wire  [bbr_pkg::CH_W-1:0]     i_in_blue,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bbr_pkg::CH_W-1:0]     o_out_red,
    output logic [bbr_pkg::CH_W-1:0]     o_out_green,
    output logic [bbr_pkg::CH_W-1:0]     o_out_blue,
    output logic                         o_last_of_frame,
    input  wire                          i_cfg_wr_en,
    input  wire  [bbr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [bbr_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import bbr_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP = (CW > CFG_W) ? CW : CFG_W;
    localparam int HCMP = (RW > CFG_W) ? RW : CFG_W;

    // configuration
    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RESET_WIDTH;
            r_cfg_height <= RESET_HEIGHT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ACTIVE_WIDTH:  r_cfg_width  <= i_cfg_wdata;
                REG_ACTIVE_HEIGHT: r_cfg_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped frame size
    logic [WCMP-1:0] w_ext;
    logic [WCMP-1:0] w_eff;
    logic [HCMP-1:0] h_ext;
    logic [HCMP-1:0] h_eff;

    always_comb begin
        w_ext = WCMP'(r_cfg_width);
        h_ext = HCMP'(r_cfg_height);
        if (w_ext == '0)
            w_eff = WCMP'(1);
        else if (w_ext > WCMP'(MAX_WIDTH))
            w_eff = WCMP'(MAX_WIDTH);
        else
            w_eff = w_ext;
        if (h_ext == '0)
            h_eff = HCMP'(1);
        else if (h_ext > HCMP'(MAX_HEIGHT))
            h_eff = HCMP'(MAX_HEIGHT);
        else
            h_eff = h_ext;
    end

    // position counters
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic          pad_col;
    logic          pad_row;
    logic          in_acc;

    assign pad_col = WCMP'(r_col) >= w_eff;
    assign pad_row = HCMP'(r_row) >= h_eff;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (pad_col) begin
                n_col = '0;
                n_row = pad_row ? '0 : RW'(r_row + 1'b1);
            end else begin
                n_col = CW'(r_col + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // pipeline control
    logic r_s1_vld;
    logic r_s2_vld;
    logic r_s3_vld;
    logic s1_emit;
    logic s1_move;
    logic s2_free;
    logic s3_free;

    assign s3_free    = !r_s3_vld || i_out_ready;
    assign s2_free    = !r_s2_vld || s3_free;
    assign s1_move    = r_s1_vld && (!s1_emit || s2_free);
    assign o_in_ready = !r_s1_vld || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (in_acc)
                r_s1_vld <= 1'b1;
            else if (s1_move)
                r_s1_vld <= 1'b0;
            if (s1_move && s1_emit)
                r_s2_vld <= 1'b1;
            else if (s3_free)
                r_s2_vld <= 1'b0;
            if (r_s2_vld && s3_free)
                r_s3_vld <= 1'b1;
            else if (i_out_ready)
                r_s3_vld <= 1'b0;
        end
    end

    // stage 1 capture, line store read issued alongside
    t_pix          r_s1_px;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_pad;
    logic          r_s1_last;
    logic          r_s1_r1;
    logic          r_s1_r2;
    logic          r_s1_c1;
    logic          r_s1_c2;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px   <= (pad_col || pad_row) ? t_pix'('0)
                                              : t_pix'({i_in_red, i_in_green, i_in_blue});
            r_s1_addr <= r_col[AW-1:0];
            r_s1_pad  <= pad_col;
            r_s1_last <= pad_col && pad_row;
            r_s1_r1   <= r_row >= RW'(1);
            r_s1_r2   <= r_row >= RW'(2);
            r_s1_c1   <= r_col >= CW'(1);
            r_s1_c2   <= r_col >= CW'(2);
        end
    end

    logic          ls_rd_en;
    logic [AW-1:0] ls_rd_addr;
    logic          ls_wr_en;
    t_pix          ls_rd_upper;
    t_pix          ls_rd_lower;

    assign ls_rd_en   = in_acc && !pad_col;
    assign ls_rd_addr = r_col[AW-1:0];
    assign ls_wr_en   = s1_move && !r_s1_pad;

    bbr_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_rd_en    (ls_rd_en),
        .i_rd_addr  (ls_rd_addr),
        .i_wr_en    (ls_wr_en),
        .i_wr_addr  (r_s1_addr),
        .i_wr_upper (ls_rd_lower),
        .i_wr_lower (r_s1_px),
        .o_rd_upper (ls_rd_upper),
        .o_rd_lower (ls_rd_lower)
    );

    // window and sums
    t_pix r_win_a [3];
    t_pix r_win_b [3];
    t_pix cur [3];
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;

    assign s1_emit = r_s1_r1 && r_s1_c1;

    always_comb begin
        cur[0] = (!r_s1_pad && r_s1_r2) ? ls_rd_upper : t_pix'('0);
        cur[1] = (!r_s1_pad && r_s1_r1) ? ls_rd_lower : t_pix'('0);
        cur[2] = r_s1_pad ? t_pix'('0) : r_s1_px;
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < 3; k++) begin
            sum_r = sum_r + SUM_W'(cur[k].red) + SUM_W'(r_win_a[k].red)
                  + (r_s1_c2 ? SUM_W'(r_win_b[k].red) : SUM_W'(0));
            sum_g = sum_g + SUM_W'(cur[k].green) + SUM_W'(r_win_a[k].green)
                  + (r_s1_c2 ? SUM_W'(r_win_b[k].green) : SUM_W'(0));
            sum_b = sum_b + SUM_W'(cur[k].blue) + SUM_W'(r_win_a[k].blue)
                  + (r_s1_c2 ? SUM_W'(r_win_b[k].blue) : SUM_W'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win_a[k] <= '0;
                r_win_b[k] <= '0;
            end
        end else if (s1_move) begin
            for (int k = 0; k < 3; k++) begin
                r_win_b[k] <= r_win_a[k];
                r_win_a[k] <= cur[k];
            end
        end
    end

    // stage 2: sums
    logic [SUM_W-1:0] r_s2_sum_r;
    logic [SUM_W-1:0] r_s2_sum_g;
    logic [SUM_W-1:0] r_s2_sum_b;
    logic             r_s2_last;

    always_ff @(posedge i_clk) begin
        if (s1_move && s1_emit && s2_free) begin
            r_s2_sum_r <= sum_r;
            r_s2_sum_g <= sum_g;
            r_s2_sum_b <= sum_b;
            r_s2_last  <= r_s1_last;
        end
    end

    // stage 3: divide by nine into the output register
    logic [CH_W-1:0] r_out_red;
    logic [CH_W-1:0] r_out_green;
    logic [CH_W-1:0] r_out_blue;
    logic            r_out_last;

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && s3_free) begin
            r_out_red   <= div9(r_s2_sum_r);
            r_out_green <= div9(r_s2_sum_g);
            r_out_blue  <= div9(r_s2_sum_b);
            r_out_last  <= r_s2_last;
        end
    end

    assign o_out_valid     = r_s3_vld;
    assign o_out_red       = r_out_red;
    assign o_out_green     = r_out_green;
    assign o_out_blue      = r_out_blue;
    assign o_last_of_frame = r_out_last;

`ifndef SYNTHESIS
    a_ls_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ls_rd_en && ls_wr_en |-> ls_rd_addr != r_s1_addr)
        else $error("line store read and write hit the same column");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_s2_sum_r <= SUM_MAX) && (r_s2_sum_g <= SUM_MAX)
                     && (r_s2_sum_b <= SUM_MAX))
        else $error("window sum above nine full-scale pixels");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && r_col == '0 && r_row == '0)
        else $error("state not cleared by reset");
`endif

endmodule

`default_nettype wire
